FILE: hw/rtl/nhl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhl_pkg
// Shared types and constants for the node heartbeat liveness table.
// ----------------------------------------------------------------------------
package nhl_pkg;

  localparam int MAX_NODES = 64;
  localparam int SLOT_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ID_W      = 32;
  localparam int IVL_W     = 16;
  localparam int TICK_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int MULT_W    = 4;
  localparam int KIND_W    = 3;
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int ALLOW_W   = MULT_W + IVL_W;

  localparam logic [PERIOD_W-1:0] SWEEP_PERIOD_RST = PERIOD_W'(100);
  localparam logic [MULT_W-1:0]   MULT_RST         = MULT_W'(5);

  localparam logic [CMD_W-1:0] CMD_CONFIG = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEAT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEAT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOST    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;

  localparam logic REG_SWEEP_PERIOD = 1'b0;
  localparam logic REG_TIMEOUT_MULT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESP,
    ST_SW_RD,
    ST_SW_EV,
    ST_SW_END
  } ctrl_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [IVL_W-1:0]  interval;
    logic [TICK_W-1:0] last_beat;
    logic              lost;
  } entry_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] sweep_period;
    logic [MULT_W-1:0]   timeout_multiplier;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [ID_W-1:0]   node_id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_word_t;

endpackage

FILE: hw/rtl/nhl_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhl_ifs
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface nhl_in_if;
  logic                       valid;
  logic                       ready;
  logic [nhl_pkg::CMD_W-1:0]  cmd;
  logic [nhl_pkg::ID_W-1:0]   node_id;
  logic [nhl_pkg::IVL_W-1:0]  interval;

  modport source (output valid, output cmd, output node_id, output interval, input ready);
  modport sink   (input valid, input cmd, input node_id, input interval, output ready);
endinterface

interface nhl_out_if;
  logic                       valid;
  logic                       ready;
  logic [nhl_pkg::KIND_W-1:0] result_kind;
  logic [nhl_pkg::ID_W-1:0]   node_id_out;
  logic [nhl_pkg::SLOT_W-1:0] slot;
  logic                       last_of_run;

  modport source (output valid, output result_kind, output node_id_out, output slot,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input node_id_out, input slot,
                  input last_of_run, output ready);
endinterface

FILE: hw/rtl/nhl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhl_cfg_regs
// APB-style register file: sweep period and timeout multiplier.
// ----------------------------------------------------------------------------
module nhl_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nhl_pkg::ADDR_W-1:0] paddr,
  input  logic [nhl_pkg::DATA_W-1:0] pwdata,
  output logic [nhl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output nhl_pkg::cfg_t              cfg
);

  logic [nhl_pkg::PERIOD_W-1:0] period_r;
  logic [nhl_pkg::MULT_W-1:0]   mult_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= nhl_pkg::SWEEP_PERIOD_RST;
      mult_r   <= nhl_pkg::MULT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        nhl_pkg::REG_SWEEP_PERIOD: period_r <= pwdata[nhl_pkg::PERIOD_W-1:0];
        nhl_pkg::REG_TIMEOUT_MULT: mult_r   <= pwdata[nhl_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nhl_pkg::REG_SWEEP_PERIOD: prdata = nhl_pkg::DATA_W'(period_r);
      nhl_pkg::REG_TIMEOUT_MULT: prdata = nhl_pkg::DATA_W'(mult_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.sweep_period       = period_r;
  assign cfg.timeout_multiplier = mult_r;

endmodule

FILE: hw/rtl/nhl_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhl_entry_ram
// Node entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nhl_entry_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [nhl_pkg::SLOT_W-1:0] waddr,
  input  nhl_pkg::entry_t            wdata,
  input  logic                       re,
  input  logic [nhl_pkg::SLOT_W-1:0] raddr,
  output nhl_pkg::entry_t            rdata
);

  nhl_pkg::entry_t mem [nhl_pkg::MAX_NODES];
  nhl_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/nhl_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhl_out_reg
// Result output register; frees the sequencer from the receiver's stalls.
// ----------------------------------------------------------------------------
module nhl_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nhl_pkg::res_word_t push_word,
  output logic              free,
  nhl_out_if.source         out_ch
);

  logic               valid_r;
  nhl_pkg::res_word_t word_r;

  assign free = ~valid_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_r <= push_word;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.result_kind = word_r.result_kind;
  assign out_ch.node_id_out = word_r.node_id;
  assign out_ch.slot        = word_r.slot;
  assign out_ch.last_of_run = word_r.last;

endmodule

FILE: hw/rtl/nhl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhl_ctrl
// Sequencer: table lookup, entry update, tick clock and timeout sweep.
// ----------------------------------------------------------------------------
module nhl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nhl_pkg::cfg_t               cfg,
  nhl_in_if.sink                      in_ch,
  output logic                        ram_we,
  output logic [nhl_pkg::SLOT_W-1:0]  ram_waddr,
  output nhl_pkg::entry_t             ram_wdata,
  output logic                        ram_re,
  output logic [nhl_pkg::SLOT_W-1:0]  ram_raddr,
  input  nhl_pkg::entry_t             ram_rdata,
  input  logic                        out_free,
  output logic                        push,
  output nhl_pkg::res_word_t          push_word
);

  nhl_pkg::ctrl_state_t state_r, state_nxt;

  logic [nhl_pkg::CNT_W-1:0]    fill_r, fill_nxt;
  logic [nhl_pkg::TICK_W-1:0]   now_r, now_nxt;
  logic [nhl_pkg::PERIOD_W-1:0] cd_r, cd_nxt;
  logic                         dvld_r, dvld_nxt;
  logic                         pend_valid_r, pend_valid_nxt;

  logic [nhl_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [nhl_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [nhl_pkg::IVL_W-1:0]    ivl_r, ivl_nxt;
  logic [nhl_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic [nhl_pkg::SLOT_W-1:0]   dslot_r, dslot_nxt;
  logic [nhl_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [nhl_pkg::SLOT_W-1:0]   rslot_r, rslot_nxt;
  logic [nhl_pkg::ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [nhl_pkg::SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;

  logic [nhl_pkg::PERIOD_W-1:0] cd_load;
  logic [nhl_pkg::ALLOW_W-1:0]  allowed;
  logic [nhl_pkg::TICK_W-1:0]   silence;
  logic                         timed_out;
  logic                         hit;

  assign allowed   = nhl_pkg::ALLOW_W'(cfg.timeout_multiplier)
                   * nhl_pkg::ALLOW_W'(ram_rdata.interval);
  assign silence   = now_r - ram_rdata.last_beat;
  assign timed_out = ~ram_rdata.lost & (silence > nhl_pkg::TICK_W'(allowed));
  assign hit       = dvld_r & (ram_rdata.node_id == id_r);
  assign cd_load   = (cd_r != '0) ? cd_r :
                     ((cfg.sweep_period != '0) ? cfg.sweep_period : nhl_pkg::PERIOD_W'(1));

  assign in_ch.ready = (state_r == nhl_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    now_nxt        = now_r;
    cd_nxt         = cd_r;
    dvld_nxt       = dvld_r;
    pend_valid_nxt = pend_valid_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    ivl_nxt        = ivl_r;
    idx_nxt        = idx_r;
    dslot_nxt      = dslot_r;
    kind_nxt       = kind_r;
    rslot_nxt      = rslot_r;
    pend_id_nxt    = pend_id_r;
    pend_slot_nxt  = pend_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = dslot_r;
    ram_wdata      = '{node_id: id_r, interval: ivl_r, last_beat: now_r, lost: 1'b0};
    ram_re         = 1'b0;
    ram_raddr      = idx_r[nhl_pkg::SLOT_W-1:0];
    push           = 1'b0;
    push_word      = '{result_kind: kind_r, node_id: id_r, slot: rslot_r, last: 1'b1};

    case (state_r)
      nhl_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          id_nxt  = in_ch.node_id;
          ivl_nxt = in_ch.interval;
          idx_nxt = '0;
          if (in_ch.cmd == nhl_pkg::CMD_TICK) begin
            now_nxt = now_r + nhl_pkg::TICK_W'(1);
            cd_nxt  = cd_load - nhl_pkg::PERIOD_W'(1);
            if (cd_nxt == '0 && fill_r != '0) begin
              pend_valid_nxt = 1'b0;
              state_nxt      = nhl_pkg::ST_SW_RD;
            end
          end else begin
            dvld_nxt  = 1'b0;
            state_nxt = nhl_pkg::ST_LOOKUP;
          end
        end
      end

      nhl_pkg::ST_LOOKUP: begin
        if (hit) begin
          rslot_nxt = dslot_r;
          state_nxt = nhl_pkg::ST_RESP;
          case (cmd_r)
            nhl_pkg::CMD_CONFIG: begin
              ram_we   = 1'b1;
              kind_nxt = nhl_pkg::KIND_ACK;
            end
            nhl_pkg::CMD_BEAT: begin
              ram_we             = 1'b1;
              ram_wdata.interval = ram_rdata.interval;
              kind_nxt           = nhl_pkg::KIND_BEAT;
            end
            default: kind_nxt = nhl_pkg::KIND_DATA;
          endcase
        end else if (!dvld_r && idx_r >= fill_r) begin
          state_nxt = nhl_pkg::ST_RESP;
          rslot_nxt = '0;
          if (cmd_r == nhl_pkg::CMD_CONFIG) begin
            if (fill_r == nhl_pkg::CNT_W'(nhl_pkg::MAX_NODES)) begin
              kind_nxt = nhl_pkg::KIND_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = fill_r[nhl_pkg::SLOT_W-1:0];
              fill_nxt  = fill_r + nhl_pkg::CNT_W'(1);
              rslot_nxt = fill_r[nhl_pkg::SLOT_W-1:0];
              kind_nxt  = nhl_pkg::KIND_ACK;
            end
          end else begin
            kind_nxt = nhl_pkg::KIND_UNKNOWN;
          end
        end else if (idx_r < fill_r) begin
          ram_re    = 1'b1;
          dvld_nxt  = 1'b1;
          dslot_nxt = idx_r[nhl_pkg::SLOT_W-1:0];
          idx_nxt   = idx_r + nhl_pkg::CNT_W'(1);
        end else begin
          dvld_nxt = 1'b0;
        end
      end

      nhl_pkg::ST_RESP: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = nhl_pkg::ST_IDLE;
        end
      end

      nhl_pkg::ST_SW_RD: begin
        if (idx_r < fill_r) begin
          ram_re    = 1'b1;
          dslot_nxt = idx_r[nhl_pkg::SLOT_W-1:0];
          idx_nxt   = idx_r + nhl_pkg::CNT_W'(1);
          state_nxt = nhl_pkg::ST_SW_EV;
        end else begin
          state_nxt = nhl_pkg::ST_SW_END;
        end
      end

      nhl_pkg::ST_SW_EV: begin
        if (!timed_out) begin
          state_nxt = nhl_pkg::ST_SW_RD;
        end else if (!pend_valid_r || out_free) begin
          push      = pend_valid_r;
          push_word = '{result_kind: nhl_pkg::KIND_LOST, node_id: pend_id_r,
                        slot: pend_slot_r, last: 1'b0};
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = ram_rdata.node_id;
          pend_slot_nxt  = dslot_r;
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata;
          ram_wdata.lost = 1'b1;
          state_nxt      = nhl_pkg::ST_SW_RD;
        end
      end

      nhl_pkg::ST_SW_END: begin
        push_word = '{result_kind: nhl_pkg::KIND_LOST, node_id: pend_id_r,
                      slot: pend_slot_r, last: 1'b1};
        if (!pend_valid_r) begin
          state_nxt = nhl_pkg::ST_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = nhl_pkg::ST_IDLE;
        end
      end

      default: state_nxt = nhl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nhl_pkg::ST_IDLE;
      fill_r       <= '0;
      now_r        <= '0;
      cd_r         <= '0;
      dvld_r       <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      now_r        <= now_nxt;
      cd_r         <= cd_nxt;
      dvld_r       <= dvld_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    ivl_r       <= ivl_nxt;
    idx_r       <= idx_nxt;
    dslot_r     <= dslot_nxt;
    kind_r      <= kind_nxt;
    rslot_r     <= rslot_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_slot_r <= pend_slot_nxt;
  end

endmodule

FILE: hw/rtl/node_heartbeat_liveness_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_heartbeat_liveness_table_core
// Node table with heartbeat refresh, data forwarding and timeout sweeps.
// ----------------------------------------------------------------------------
// Input words (in_ch) carry config, heartbeat, data or one-tick commands;
// result words (out_ch) carry ack, connected, forward, lost, unknown or full,
// with last_of_run set on the final word caused by an input word.
// One input word is taken at a time: in_ch.ready is high only when idle.
// Config, heartbeat and data words walk the occupied slots through the
// entry memory, one slot a cycle, up to the result register. A sweep
// tick walks the occupied slots with a read and an evaluation per entry
// and a write for each lost one, that slot walk being the limiting path.
// The last lost node of a sweep is held until the walk ends so that it can
// carry last_of_run. A stalled receiver holds the result register; the
// sweep then pauses on the next lost node until the register frees.
// Reset (rst_n, synchronous) empties the table through the fill count,
// zeroes the tick clock and sweep countdown and restores the registers
// (sweep period 100, timeout multiplier 5); no clearing pass is needed.
// ----------------------------------------------------------------------------
module node_heartbeat_liveness_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  nhl_in_if.sink                     in_ch,
  nhl_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nhl_pkg::ADDR_W-1:0] paddr,
  input  logic [nhl_pkg::DATA_W-1:0] pwdata,
  output logic [nhl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  nhl_pkg::cfg_t             cfg;
  logic                      ram_we;
  logic [nhl_pkg::SLOT_W-1:0] ram_waddr;
  nhl_pkg::entry_t           ram_wdata;
  logic                      ram_re;
  logic [nhl_pkg::SLOT_W-1:0] ram_raddr;
  nhl_pkg::entry_t           ram_rdata;
  logic                      out_free;
  logic                      push;
  nhl_pkg::res_word_t        push_word;

  nhl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nhl_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nhl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .push      (push),
    .push_word (push_word)
  );

  nhl_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

FILE: sim/node_heartbeat_liveness_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_heartbeat_liveness_table_core_test
// Checks node registration, heartbeat refresh, data forwarding, table-full
// flagging and timeout sweeps against a cycle-free model of the node table.
// A directed opening is followed by random bus traffic over several register
// settings and idling mixes, including one long receiver hold-off. Every
// result word is compared field by field with the model's oldest prediction.
// ----------------------------------------------------------------------------
module node_heartbeat_liveness_table_core_test;
  import nhl_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 1500000;

  localparam logic [ADDR_W-1:0] ADDR_SWEEP_PERIOD = {REG_SWEEP_PERIOD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT_MULT = {REG_TIMEOUT_MULT, 2'b00};

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_LIVE = 2'd1,
    SLOT_LOST = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  node_id;
    logic [IVL_W-1:0] interval;
  } bus_msg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  nhl_in_if  in_ch ();
  nhl_out_if out_ch ();

  node_heartbeat_liveness_table_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  bus_msg_t         msg_q[$];
  res_word_t        expected_reports[$];
  logic [ID_W-1:0]  known_ids[$];

  // node table as the block should hold it
  logic [ID_W-1:0]   tbl_id    [MAX_NODES];
  slot_state_t       tbl_state [MAX_NODES];
  logic [IVL_W-1:0]  tbl_ivl   [MAX_NODES];
  logic [TICK_W-1:0] tbl_beat  [MAX_NODES];
  int                tbl_fill = 0;
  logic [TICK_W-1:0] now_ms = '0;
  logic [PERIOD_W-1:0] sweep_left = '0;
  logic [PERIOD_W-1:0] cfg_period = SWEEP_PERIOD_RST;
  logic [MULT_W-1:0]   cfg_mult = MULT_RST;

  int send_gap_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;

  int msgs_taken = 0;
  int words_checked = 0;
  int lost_words = 0;
  int full_words = 0;
  int mismatches = 0;

  function automatic void queue_report(input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] id, input int slot);
    res_word_t w;
    w.result_kind = kind;
    w.node_id = id;
    w.slot = SLOT_W'(slot);
    w.last = 1'b0;
    expected_reports.push_back(w);
  endfunction

  function automatic void advance_node_table(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic [IVL_W-1:0] ivl);
    int hit;
    int n;
    res_word_t w;
    logic [TICK_W-1:0] silence;
    logic [TICK_W-1:0] allowed;
    hit = -1;
    n = 0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (i < tbl_fill && tbl_state[i] != SLOT_FREE && tbl_id[i] == id) hit = i;
    end
    case (cmd)
      CMD_CONFIG: begin
        if (hit < 0 && tbl_fill >= MAX_NODES) begin
          queue_report(KIND_FULL, id, 0);
        end else begin
          if (hit < 0) begin
            hit = tbl_fill;
            tbl_fill++;
            tbl_id[hit] = id;
          end
          tbl_ivl[hit] = ivl;
          tbl_state[hit] = SLOT_LIVE;
          tbl_beat[hit] = now_ms;
          queue_report(KIND_ACK, id, hit);
        end
        n = 1;
      end
      CMD_BEAT, CMD_DATA: begin
        if (hit < 0) begin
          queue_report(KIND_UNKNOWN, id, 0);
        end else if (cmd == CMD_BEAT) begin
          tbl_beat[hit] = now_ms;
          tbl_state[hit] = SLOT_LIVE;
          queue_report(KIND_BEAT, id, hit);
        end else begin
          queue_report(KIND_DATA, id, hit);
        end
        n = 1;
      end
      default: begin
        now_ms = now_ms + 1;
        if (sweep_left == 0) sweep_left = (cfg_period == 0) ? PERIOD_W'(1) : cfg_period;
        sweep_left = sweep_left - 1'b1;
        if (sweep_left == 0) begin
          for (int i = 0; i < tbl_fill && n < MAX_NODES; i++) begin
            if (tbl_state[i] == SLOT_LIVE) begin
              silence = now_ms - tbl_beat[i];
              allowed = TICK_W'(cfg_mult) * TICK_W'(tbl_ivl[i]);
              if (silence > allowed) begin
                tbl_state[i] = SLOT_LOST;
                queue_report(KIND_LOST, tbl_id[i], i);
                n++;
              end
            end
          end
        end
      end
    endcase
    if (n > 0) begin
      w = expected_reports.pop_back();
      w.last = 1'b1;
      expected_reports.push_back(w);
    end
  endfunction

  // input side: one word offered at a time, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_node_table(in_ch.cmd, in_ch.node_id, in_ch.interval);
        msgs_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (msg_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin : offer
          bus_msg_t m;
          m = msg_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.cmd      <= m.cmd;
          in_ch.node_id  <= m.node_id;
          in_ch.interval <= m.interval;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : rx_mon
    res_word_t got;
    res_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind = out_ch.result_kind;
        got.node_id = out_ch.node_id_out;
        got.slot = out_ch.slot;
        got.last = out_ch.last_of_run;
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word kind %0d id %h slot %0d last %0b", $time,
                     got.result_kind, got.node_id, got.slot, got.last);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          words_checked++;
          if (want.result_kind == KIND_LOST) lost_words++;
          if (want.result_kind == KIND_FULL) full_words++;
          if (got.result_kind != want.result_kind || got.node_id != want.node_id ||
              got.slot != want.slot || got.last != want.last) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch exp kind %0d id %h slot %0d last %0b",
                       $time, want.result_kind, want.node_id, want.slot, want.last);
              $display("%0t:          got kind %0d id %h slot %0d last %0b",
                       $time, got.result_kind, got.node_id, got.slot, got.last);
            end
            mismatches++;
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  task automatic push_msg(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                          input logic [IVL_W-1:0] ivl);
    bus_msg_t m;
    m.cmd = cmd;
    m.node_id = id;
    m.interval = ivl;
    msg_q.push_back(m);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SWEEP_PERIOD) cfg_period = value[PERIOD_W-1:0];
    else if (addr == ADDR_TIMEOUT_MULT) cfg_mult = value[MULT_W-1:0];
  endtask

  task automatic set_liveness_params(input int period, input int mult);
    cfg_write(ADDR_SWEEP_PERIOD, DATA_W'(period));
    cfg_write(ADDR_TIMEOUT_MULT, DATA_W'(mult));
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (msg_q.size() != 0 || in_ch.valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] fresh_node_id();
    logic [ID_W-1:0] id;
    bit clash;
    do begin
      id = $urandom();
      clash = 1'b0;
      foreach (known_ids[j]) if (known_ids[j] == id) clash = 1'b1;
    end while (clash);
    return id;
  endfunction

  // mostly short intervals so that timeouts actually happen
  function automatic logic [IVL_W-1:0] rand_interval();
    int r;
    r = $urandom_range(99);
    if (r < 80) return IVL_W'($urandom_range(12));
    if (r < 95) return IVL_W'($urandom_range(200, 13));
    return IVL_W'($urandom());
  endfunction

  task automatic queue_random_traffic(input int count);
    int pick;
    logic [ID_W-1:0] id;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_msg(CMD_TICK, $urandom(), IVL_W'($urandom()));
      end else if (pick < 80) begin
        if (known_ids.size() != 0 && $urandom_range(99) < 85)
          id = known_ids[$urandom_range(known_ids.size() - 1)];
        else
          id = fresh_node_id();
        push_msg((pick < 65) ? CMD_BEAT : CMD_DATA, id, IVL_W'($urandom()));
      end else begin
        if (known_ids.size() != 0 && $urandom_range(1) == 0) begin
          id = known_ids[$urandom_range(known_ids.size() - 1)];
        end else begin
          id = fresh_node_id();
          if (known_ids.size() < MAX_NODES) known_ids.push_back(id);
        end
        push_msg(CMD_CONFIG, id, rand_interval());
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.node_id = '0;
    in_ch.interval = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      tbl_state[i] = SLOT_FREE;
      tbl_id[i] = '0;
      tbl_ivl[i] = '0;
      tbl_beat[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unknown senders, field extremes, update, loss and reconnection
    set_liveness_params(2, 1);
    known_ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A};
    push_msg(CMD_BEAT,   32'h0000_0000, 16'h0000);
    push_msg(CMD_DATA,   32'hFFFF_FFFF, 16'hFFFF);
    push_msg(CMD_CONFIG, 32'h0000_0000, 16'h0000);
    push_msg(CMD_CONFIG, 32'hFFFF_FFFF, 16'hFFFF);
    push_msg(CMD_CONFIG, 32'hA5A5_A5A5, 16'h0001);
    push_msg(CMD_CONFIG, 32'h5A5A_5A5A, 16'h0002);
    push_msg(CMD_DATA,   32'hFFFF_FFFF, 16'h0000);
    push_msg(CMD_BEAT,   32'h0000_0000, 16'hFFFF);
    push_msg(CMD_CONFIG, 32'h0000_0000, 16'h0003);
    push_msg(CMD_TICK,   32'hFFFF_FFFF, 16'hFFFF);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    push_msg(CMD_TICK,   32'hFFFF_FFFF, 16'hFFFF);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    push_msg(CMD_BEAT,   32'hA5A5_A5A5, 16'h0000);
    push_msg(CMD_DATA,   32'h5A5A_5A5A, 16'h0000);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    push_msg(CMD_CONFIG, 32'h5A5A_5A5A, 16'h0000);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    push_msg(CMD_TICK,   32'h0000_0000, 16'h0000);
    wait_drained();

    // sweep every tick, widest multiplier, sender idling
    set_liveness_params(1, 15);
    send_gap_pct = 55;
    stall_pct = 0;
    queue_random_traffic(110);
    wait_drained();

    // fill the table, then overflow it; receiver stalling
    set_liveness_params(5, 1);
    send_gap_pct = 0;
    stall_pct = 55;
    while (known_ids.size() < MAX_NODES) begin : fill
      logic [ID_W-1:0] id;
      id = fresh_node_id();
      known_ids.push_back(id);
      push_msg(CMD_CONFIG, id, rand_interval());
    end
    repeat (3) push_msg(CMD_CONFIG, fresh_node_id(), rand_interval());
    queue_random_traffic(90);
    wait_drained();

    // both sides idling, with a long hold-off on the result side
    set_liveness_params(3, 2);
    send_gap_pct = 12;
    stall_pct = 12;
    hold_req = 1'b1;
    queue_random_traffic(110);
    wait_drained();

    // longest sweep period last: the countdown never reloads afterwards
    set_liveness_params(65535, 7);
    send_gap_pct = 0;
    stall_pct = 0;
    queue_random_traffic(60);
    wait_drained();

    $display("Sent %0d words under five register settings and four idling mixes.",
             msgs_taken);
    $display("Checked %0d result words: %0d node losses, %0d table-full answers.",
             words_checked, lost_words, full_words);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: node_heartbeat_liveness_table_core.f
hw/rtl/nhl_pkg.sv
hw/rtl/nhl_ifs.sv
hw/rtl/nhl_cfg_regs.sv
hw/rtl/nhl_entry_ram.sv
hw/rtl/nhl_out_reg.sv
hw/rtl/nhl_ctrl.sv
hw/rtl/node_heartbeat_liveness_table_core.sv
sim/node_heartbeat_liveness_table_core_test.sv
